/* sv/phbf_pkg.sv */
// Shared constants and types for the pixel HSV fade blend block.
// No dependencies; compiled first.
package phbf_pkg;

   localparam int IDX_W  = 10;
   localparam int OFS_W  = 11;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 11;

   localparam logic [CNT_W-1:0]  COUNT_RESET   = 11'd1024;
   localparam logic [BYTE_W-1:0] SECTION_STEPS = 8'd86;
   localparam logic [BYTE_W-1:0] BYTE_MAX      = 8'd255;
   localparam logic [OFS_W-1:0]  OFFSET_BLACK  = 11'h7FF;

   // x / 86 == (x * DIV86_MUL) >> DIV86_SHIFT for x below 2^15
   localparam logic [14:0] DIV86_MUL   = 15'd24386;
   localparam int          DIV86_SHIFT = 21;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] remainder;
   } mod_sts_type;

endpackage

/* sv/phbf_if.sv */
// Valid/ready channel interfaces for the request and response transactions.
// Depends on phbf_pkg for field widths.
interface phbf_req_if;
   logic                               valid;
   logic                               ready;
   logic        [phbf_pkg::IDX_W-1:0]  led_index;
   logic signed [phbf_pkg::OFS_W-1:0]  led_offset;
   logic        [phbf_pkg::BYTE_W-1:0] hue;
   logic        [phbf_pkg::BYTE_W-1:0] saturation;
   logic        [phbf_pkg::BYTE_W-1:0] brightness;
   logic        [phbf_pkg::BYTE_W-1:0] fade_weight;

   modport source (output valid, led_index, led_offset, hue, saturation, brightness,
                   fade_weight, input ready);
   modport sink   (input valid, led_index, led_offset, hue, saturation, brightness,
                   fade_weight, output ready);
endinterface

interface phbf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [phbf_pkg::IDX_W-1:0]  pixel_index;
   logic [phbf_pkg::BYTE_W-1:0] red;
   logic [phbf_pkg::BYTE_W-1:0] green;
   logic [phbf_pkg::BYTE_W-1:0] blue;

   modport source (output valid, pixel_index, red, green, blue, input ready);
   modport sink   (input valid, pixel_index, red, green, blue, output ready);
endinterface

/* sv/phbf_mod_unit.sv */
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on phbf_pkg for the request and status structs.
module phbf_mod_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  phbf_pkg::mod_req_type ctl,
   output phbf_pkg::mod_sts_type sts
);
   import phbf_pkg::*;

   localparam int STEP_W = $clog2(CNT_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W-1:0]  mag_ff;
   logic [CNT_W-1:0]  div_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   assign trial = {rem_ff, mag_ff[CNT_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !ctl.start && busy_ff && (step_ff == STEP_W'(CNT_W - 1));
         if (ctl.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == STEP_W'(CNT_W - 1)) begin
               busy_ff <= 1'b0;
            end
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         mag_ff <= ctl.dividend;
         div_ff <= ctl.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[CNT_W-2:0], 1'b0};
         // borrow means the trial stays below the divisor
         rem_ff <= diff[CNT_W] ? trial[CNT_W-1:0] : diff[CNT_W-1:0];
      end
   end

   assign sts.done      = done_ff;
   assign sts.remainder = rem_ff;

endmodule

/* sv/pixel_hsv_fade_blend_core.sv */
// Requests are taken only in the idle state, after the previous one is written;
// each runs the 11-step remainder loop and then the single shared multiplier.
// The pixel store is a one-port-write, one-port-read memory of LED_COUNT words.
// Reset is synchronous: after it every word of the store is swept to black
// with req ready low; the LED count register resets to 1024.
// Depends on phbf_pkg, phbf_if and phbf_mod_unit.
module pixel_hsv_fade_blend_core #(
   parameter int LED_COUNT = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   phbf_req_if.sink                     req_ch,
   phbf_rsp_if.source                   rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [phbf_pkg::CNT_W-1:0]   csr_wr_data
);
   import phbf_pkg::*;

   localparam int AW = $clog2(LED_COUNT);

   typedef enum logic [12:0] {
      ST_CLEAR = 13'b0000000000001,
      ST_IDLE  = 13'b0000000000010,
      ST_MOD   = 13'b0000000000100,
      ST_READ  = 13'b0000000001000,
      ST_MUL_F = 13'b0000000010000,
      ST_MUL_U = 13'b0000000100000,
      ST_DIV_U = 13'b0000001000000,
      ST_MUL_D = 13'b0000010000000,
      ST_DIV_D = 13'b0000100000000,
      ST_OLD_R = 13'b0001000000000,
      ST_OLD_G = 13'b0010000000000,
      ST_OLD_B = 13'b0100000000000,
      ST_WRITE = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  n;
   logic [AW-1:0]     clr_addr_ff;
   logic              accept;
   logic              out_free;
   logic              write_go;

   logic signed [11:0] sum;
   logic [11:0]        neg_sum;
   logic [CNT_W-1:0]   mag;
   logic [1:0]         sec;
   logic [6:0]         ofs;
   logic [CNT_W-1:0]   pos_full;

   mod_req_type mod_req;
   mod_sts_type mod_sts;

   logic [1:0]        sec_ff;
   logic [6:0]        ofs_ff;
   logic [BYTE_W-1:0] sat_ff, val_ff, fade_ff;
   logic              neg_ff, black_ff;
   logic [AW-1:0]     pos_ff;

   logic [14:0]       mul_a, mul_b;
   logic [29:0]       prod_ff;
   logic [BYTE_W-1:0] v_ff, floor_ff, amp_ff, up_ff, down_ff, red_ff, green_ff;
   logic [BYTE_W-1:0] col_r, col_g, col_b, blue_new;
   logic [BYTE_W-1:0] keep;

   logic [23:0]       mem [LED_COUNT];
   logic [23:0]       rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [23:0]       mem_wd;

   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [BYTE_W-1:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;

   // old * keep / 255, exact for products of two bytes, then saturating add
   function automatic logic [BYTE_W-1:0] blend(input logic [BYTE_W-1:0] c,
                                               input logic [15:0] p);
      logic [16:0] t;
      logic [8:0]  s;
      t = 17'(p) + 17'd1 + 17'(p[15:8]);
      s = {1'b0, c} + {1'b0, t[15:8]};
      return s[8] ? BYTE_MAX : s[7:0];
   endfunction

   // ---- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         n = CNT_W'(1);
      end else if ({2'b00, count_ff} > 13'(LED_COUNT)) begin
         n = CNT_W'(LED_COUNT);
      end else begin
         n = count_ff;
      end
   end

   // ---- request decode
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign sum     = $signed({2'b00, req_ch.led_index})
                  + $signed({req_ch.led_offset[OFS_W-1], req_ch.led_offset});
   assign neg_sum = -sum;
   assign mag     = sum[11] ? neg_sum[CNT_W-1:0] : sum[CNT_W-1:0];

   always_comb begin
      if (req_ch.hue >= 8'(2 * SECTION_STEPS)) begin
         sec = 2'd2;
         ofs = 7'(req_ch.hue - 8'(2 * SECTION_STEPS));
      end else if (req_ch.hue >= SECTION_STEPS) begin
         sec = 2'd1;
         ofs = 7'(req_ch.hue - SECTION_STEPS);
      end else begin
         sec = 2'd0;
         ofs = 7'(req_ch.hue);
      end
   end

   assign mod_req.start    = accept;
   assign mod_req.dividend = mag;
   assign mod_req.divisor  = n;

   phbf_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .ctl   (mod_req),
      .sts   (mod_sts)
   );

   // C-style remainder is negative for a negative sum; wrap it into range
   assign pos_full = (neg_ff && mod_sts.remainder != '0) ? n - mod_sts.remainder
                                                          : mod_sts.remainder;

   // ---- sequencer
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign write_go = (state_ff == ST_WRITE) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_addr_ff == AW'(LED_COUNT - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_MOD;
         ST_MOD:   if (mod_sts.done) state_in = ST_READ;
         ST_READ:  state_in = ST_MUL_F;
         ST_MUL_F: state_in = ST_MUL_U;
         ST_MUL_U: state_in = ST_DIV_U;
         ST_DIV_U: state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_DIV_D;
         ST_DIV_D: state_in = ST_OLD_R;
         ST_OLD_R: state_in = ST_OLD_G;
         ST_OLD_G: state_in = ST_OLD_B;
         ST_OLD_B: state_in = ST_WRITE;
         ST_WRITE: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // ---- shared multiplier
   assign keep = BYTE_MAX - fade_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_READ: begin
            mul_a = 15'(val_ff);
            mul_b = 15'(fade_ff);
         end
         ST_MUL_F: begin
            mul_a = 15'(prod_ff[15:8]);
            mul_b = 15'(BYTE_MAX - sat_ff);
         end
         ST_MUL_U: begin
            mul_a = 15'(ofs_ff);
            mul_b = 15'(v_ff - prod_ff[15:8]);
         end
         ST_DIV_U, ST_DIV_D: begin
            mul_a = prod_ff[14:0];
            mul_b = DIV86_MUL;
         end
         ST_MUL_D: begin
            mul_a = 15'(SECTION_STEPS - 8'd1 - 8'(ofs_ff));
            mul_b = 15'(amp_ff);
         end
         ST_OLD_R: begin
            mul_a = 15'(rd_data_ff[23:16]);
            mul_b = 15'(keep);
         end
         ST_OLD_G: begin
            mul_a = 15'(rd_data_ff[15:8]);
            mul_b = 15'(keep);
         end
         ST_OLD_B: begin
            mul_a = 15'(rd_data_ff[7:0]);
            mul_b = 15'(keep);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      case (sec_ff)
         2'd0: begin
            col_r = down_ff;
            col_g = up_ff;
            col_b = floor_ff;
         end
         2'd1: begin
            col_r = floor_ff;
            col_g = down_ff;
            col_b = up_ff;
         end
         default: begin
            col_r = up_ff;
            col_g = floor_ff;
            col_b = down_ff;
         end
      endcase
   end

   assign blue_new = blend(col_b, prod_ff[15:0]);

   always_ff @(posedge clock) begin
      if (accept) begin
         sec_ff   <= sec;
         ofs_ff   <= ofs;
         sat_ff   <= req_ch.saturation;
         val_ff   <= req_ch.brightness;
         fade_ff  <= req_ch.fade_weight;
         neg_ff   <= sum[11];
         black_ff <= (req_ch.led_offset == OFFSET_BLACK);
      end
      if (state_ff == ST_MOD && mod_sts.done) begin
         pos_ff <= AW'(pos_full);
      end
      if (state_ff != ST_WRITE) begin
         prod_ff <= mul_a * mul_b;
      end
      case (state_ff)
         ST_MUL_F: v_ff <= prod_ff[15:8];
         ST_MUL_U: begin
            floor_ff <= prod_ff[15:8];
            amp_ff   <= v_ff - prod_ff[15:8];
         end
         ST_MUL_D: up_ff    <= prod_ff[DIV86_SHIFT+7:DIV86_SHIFT] + floor_ff;
         ST_OLD_R: down_ff  <= prod_ff[DIV86_SHIFT+7:DIV86_SHIFT] + floor_ff;
         ST_OLD_G: red_ff   <= blend(col_r, prod_ff[15:0]);
         ST_OLD_B: green_ff <= blend(col_g, prod_ff[15:0]);
         default: ;
      endcase
   end

   // ---- pixel store
   assign mem_we = (state_ff == ST_CLEAR) || write_go;
   assign mem_wa = (state_ff == ST_CLEAR) ? clr_addr_ff : pos_ff;
   assign mem_wd = (state_ff == ST_CLEAR || black_ff) ? '0
                                                       : {red_ff, green_ff, blue_new};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[pos_ff];
   end

   // ---- response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (write_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (write_go) begin
         rsp_idx_ff <= IDX_W'(pos_ff);
         rsp_r_ff   <= mem_wd[23:16];
         rsp_g_ff   <= mem_wd[15:8];
         rsp_b_ff   <= mem_wd[7:0];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_index = rsp_idx_ff;
   assign rsp_ch.red         = rsp_r_ff;
   assign rsp_ch.green       = rsp_g_ff;
   assign rsp_ch.blue        = rsp_b_ff;

`ifndef SYNTH
   a_accept_starts_mod: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_MOD))
      else $error("accepted transaction did not start the remainder step");

   a_done_only_in_mod: assert property (@(posedge clock) disable iff (reset)
      mod_sts.done |-> (state_ff == ST_MOD))
      else $error("remainder unit finished outside its step");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (13'(pos_ff) < 13'(n)))
      else $error("pixel address not below the LED count");

   a_write_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      write_go |=> rsp_ch.valid)
      else $error("pixel write without a response");
`endif

endmodule
